>>> rtl/hhls_pkg.sv
// Shared types and constants for the HTTP header line splitter.
// No dependencies; used by every module under rtl/.
package hhls_pkg;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  typedef enum logic [1:0] {
    PH_NAME  = 2'd0,
    PH_SKIP  = 2'd1,
    PH_VALUE = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    KIND_NAME    = 3'd0,
    KIND_VALUE   = 3'd1,
    KIND_LINE    = 3'd2,
    KIND_BLOCK   = 3'd3,
    KIND_DISCARD = 3'd4
  } kind_e;

  // one result
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } res_t;

  // all results of one input item (cnt is 1 or 2 when queued)
  typedef struct packed {
    logic [1:0] cnt;
    res_t       res1;
    res_t       res0;
  } job_t;

  // outcome of one content byte in the current part
  typedef struct packed {
    phase_e ph;
    logic   emit;
    kind_e  kind;
  } content_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic content_t content_step(phase_e ph, logic [7:0] b);
    content_t r;
    r.ph   = ph;
    r.emit = 1'b0;
    r.kind = KIND_VALUE;
    unique case (ph)
      PH_NAME: begin
        if (b == CH_COLON) begin
          r.ph = PH_SKIP;
        end else begin
          r.emit = 1'b1;
          r.kind = KIND_NAME;
        end
      end
      PH_SKIP: begin
        if (b != CH_SPACE) begin
          r.ph   = PH_VALUE;
          r.emit = 1'b1;
        end
      end
      default: begin
        r.emit = 1'b1;
      end
    endcase
    return r;
  endfunction

endpackage

>>> rtl/hhls_front.sv
// Front part: accepts bytes, tracks line state, packs each byte's results into a job.
// Depends on hhls_pkg.
module hhls_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                start_flag_i,
  input  hhls_pkg::fifo_stat_t stat_i,
  output logic                push_o,
  output hhls_pkg::job_t      job_o
);

  hhls_pkg::phase_e ph_q, ph_d;
  logic crp_q, crp_d, als_q, als_d, bd_q, bd_d;

  hhls_pkg::res_t [3:0] ev;
  logic [3:0]           ev_v;
  logic                 accept;

  assign in_ready_o = !stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    logic                unf;
    hhls_pkg::content_t  c;
    logic [1:0]          cnt;
    unf   = (!als_q || crp_q) && !bd_q;
    ph_d  = ph_q;
    crp_d = crp_q;
    als_d = als_q;
    bd_d  = bd_q;
    ev_v  = '0;
    for (int i = 0; i < 4; i++) begin
      ev[i] = '{kind: hhls_pkg::KIND_DISCARD, data: 8'h00};
    end
    c = '0;

    // new buffer: drop an unfinished line, then back to reset state
    if (start_flag_i) begin
      ev_v[0] = unf;
      ph_d    = hhls_pkg::PH_NAME;
      crp_d   = 1'b0;
      als_d   = 1'b1;
      bd_d    = 1'b0;
      unf     = 1'b0;
    end

    if (!bd_d) begin
      if (data_byte_i == hhls_pkg::CH_NUL) begin
        ev_v[1] = unf;
        ph_d    = hhls_pkg::PH_NAME;
        crp_d   = 1'b0;
        als_d   = 1'b1;
        bd_d    = 1'b1;
      end else if (crp_d && data_byte_i == hhls_pkg::CH_LF) begin
        ev_v[1]    = 1'b1;
        ev[1].kind = als_d ? hhls_pkg::KIND_BLOCK : hhls_pkg::KIND_LINE;
        bd_d       = als_d;
        ph_d       = hhls_pkg::PH_NAME;
        crp_d      = 1'b0;
        als_d      = 1'b1;
      end else begin
        // a held CR that is not part of CRLF is plain content
        if (crp_d) begin
          crp_d   = 1'b0;
          als_d   = 1'b0;
          c       = hhls_pkg::content_step(ph_d, hhls_pkg::CH_CR);
          ph_d    = c.ph;
          ev_v[2] = c.emit;
          ev[2]   = '{kind: c.kind, data: hhls_pkg::CH_CR};
        end
        if (data_byte_i == hhls_pkg::CH_CR) begin
          crp_d = 1'b1;
        end else begin
          als_d   = 1'b0;
          c       = hhls_pkg::content_step(ph_d, data_byte_i);
          ph_d    = c.ph;
          ev_v[3] = c.emit;
          ev[3]   = '{kind: c.kind, data: data_byte_i};
        end
      end
    end

    // compact events into at most two slots, in order
    job_o = '0;
    cnt   = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (ev_v[i]) begin
        if (cnt == 2'd0) begin
          job_o.res0 = ev[i];
        end else begin
          job_o.res1 = ev[i];
        end
        cnt = cnt + 2'd1;
      end
    end
    job_o.cnt = cnt;
  end

  assign push_o = accept && (job_o.cnt != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= hhls_pkg::PH_NAME;
      crp_q <= 1'b0;
      als_q <= 1'b1;
      bd_q  <= 1'b0;
    end else if (accept) begin
      ph_q  <= ph_d;
      crp_q <= crp_d;
      als_q <= als_d;
      bd_q  <= bd_d;
    end
  end

endmodule

>>> rtl/hhls_fifo.sv
// Short job queue between front and back parts.
// Depends on hhls_pkg.
module hhls_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  hhls_pkg::job_t       job_i,
  input  logic                 pop_i,
  output hhls_pkg::job_t       head_o,
  output hhls_pkg::fifo_stat_t stat_o
);

  hhls_pkg::job_t mem_q [hhls_pkg::FifoDepth];
  logic [hhls_pkg::FifoAw:0] wr_q, rd_q;
  logic [hhls_pkg::FifoAw:0] used;

  assign used         = wr_q - rd_q;
  assign stat_o.full  = (used == (hhls_pkg::FifoAw + 1)'(hhls_pkg::FifoDepth));
  assign stat_o.empty = (used == '0);
  assign head_o       = mem_q[rd_q[hhls_pkg::FifoAw-1:0]];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q[hhls_pkg::FifoAw-1:0]] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
    end
  end

endmodule

>>> rtl/hhls_back.sv
// Back part: unpacks queued jobs into single results held in an output register.
// Depends on hhls_pkg.
module hhls_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hhls_pkg::job_t       head_i,
  input  hhls_pkg::fifo_stat_t stat_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           kind_o,
  output logic [7:0]           out_byte_o,
  output logic                 last_of_run_o
);

  logic           vld_q, vld_d;
  logic           sel_q, sel_d;
  hhls_pkg::res_t res_q, res_d;
  logic           last_q, last_d;
  logic           load;

  assign load = !vld_q || out_ready_i;

  always_comb begin
    vld_d  = vld_q;
    sel_d  = sel_q;
    res_d  = res_q;
    last_d = last_q;
    pop_o  = 1'b0;
    if (load) begin
      vld_d = !stat_i.empty;
      if (!stat_i.empty) begin
        res_d  = sel_q ? head_i.res1 : head_i.res0;
        last_d = sel_q || (head_i.cnt == 2'd1);
        pop_o  = last_d;
        sel_d  = !last_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      sel_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      sel_q <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    last_q <= last_d;
  end

  assign out_valid_o   = vld_q;
  assign kind_o        = res_q.kind;
  assign out_byte_o    = res_q.data;
  assign last_of_run_o = last_q;

endmodule

>>> rtl/http_header_line_splitter.sv
// HTTP header line splitter: one header byte in, name/value/marker items out.
// Each taken byte's results pass through the job queue, then the output register.
// Throughput: one byte per cycle while out_ready_i is high and each byte gives at
//   most one result; a byte giving two results holds the single output register
//   for both in turn, and the 4-job queue absorbs that before in_ready_o drops.
// Reset (rst_ni, async, active low): line state to name part, queue and output empty.
module http_header_line_splitter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       start_flag_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] kind_o,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);

  // Front classifies each byte and packs up to two results into a job.
  // Bytes that cause nothing (colon, skipped spaces, held CR, ignored tail)
  // update state but never occupy the queue.
  hhls_pkg::job_t       push_job;
  hhls_pkg::job_t       head_job;
  hhls_pkg::fifo_stat_t stat;
  logic                 push;
  logic                 pop;

  hhls_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .start_flag_i (start_flag_i),
    .stat_i       (stat),
    .push_o       (push),
    .job_o        (push_job)
  );

  // Queue decouples the byte side from the result side.
  hhls_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .head_o (head_job),
    .stat_o (stat)
  );

  // Back emits one result per cycle unless stalled; last_of_run marks job end.
  hhls_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_job),
    .stat_i        (stat),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

>>> rtl/hhls_checker.sv
// Port-level checks for the HTTP header line splitter, bound to the top level.
// Depends on hhls_pkg and http_header_line_splitter.
module hhls_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] kind_o,
  input logic [7:0] out_byte_o,
  input logic       last_of_run_o
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o)
      && $stable(out_byte_o) && $stable(last_of_run_o))
    else $error("result item changed while stalled");

  // the sender sees a defined ready whenever it offers a byte
  a_ready_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i |-> !$isunknown(in_ready_o))
    else $error("input ready unknown");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> kind_o <= 3'(hhls_pkg::KIND_DISCARD))
    else $error("kind out of range");

  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == 3'(hhls_pkg::KIND_LINE) || kind_o == 3'(hhls_pkg::KIND_BLOCK)
      || kind_o == 3'(hhls_pkg::KIND_DISCARD)) |-> out_byte_o == 8'h00)
    else $error("marker item carries a byte");

  // a CRLF result is the last result of its byte
  a_term_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == 3'(hhls_pkg::KIND_LINE) || kind_o == 3'(hhls_pkg::KIND_BLOCK))
      |-> last_of_run_o)
    else $error("line or block end not last of run");

endmodule

bind http_header_line_splitter hhls_checker u_hhls_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .kind_o        (kind_o),
  .out_byte_o    (out_byte_o),
  .last_of_run_o (last_of_run_o)
);
